### src/pdt_pkg.sv
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared types, control-byte bit positions and period helper for the
// programmable divider timer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

	// counter and period width
	localparam int unsigned CNT_W = 25;

	// command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// control byte bit positions
	localparam int unsigned CB_RANGE = 4;
	localparam int unsigned CB_SET   = 5;
	localparam int unsigned CB_RESET = 6;
	localparam int unsigned CB_PAUSE = 7;

	// period bases for the short and long ranges
	localparam logic [CNT_W-1:0] SHORT_BASE = CNT_W'(2);
	localparam logic [CNT_W-1:0] LONG_BASE  = CNT_W'(512);

	// input beat
	typedef struct packed {
		logic       command;
		logic [7:0] control_byte;
	} in_t;

	// result beat
	typedef struct packed {
		logic timer_level;
		logic interrupt;
	} out_t;

	// period selected by a control byte
	function automatic logic [CNT_W-1:0] period_of(input logic [7:0] cb);
		logic [CNT_W-1:0] base;
		base = cb[CB_RANGE] ? SHORT_BASE : LONG_BASE;
		return base << cb[3:0];
	endfunction

endpackage

`default_nettype wire

### src/programmable_divider_timer_unit.sv
// ----------------------------------------------------------------------------
// programmable_divider_timer_unit
// Binary divider timer with square-wave mode, driven by tick and
// control-byte beats, with a two-entry output register and skid stage.
// ----------------------------------------------------------------------------
// Each input beat is a tick or a control-byte write and gives exactly one
// result beat with the timer level and an interrupt flag. The timer state is
// updated in the cycle the beat is accepted, so one beat is taken every
// clock while in_ready is high; each result is registered in the output
// register, or in the skid stage while that is held. The skid stage keeps
// in_ready a registered signal: the block takes beats while a result waits,
// and stalls only once both result slots hold beats not yet taken.
`default_nettype none

module programmable_divider_timer_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pdt_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output pdt_pkg::out_t      out_data
);

	// timer state
	logic [pdt_pkg::CNT_W-1:0] tick_count_q, period_q;
	logic                      square_mode_q, paused_q, output_level_q;

	// output register and skid stage
	logic          out_valid_q, skid_valid_q;
	pdt_pkg::out_t out_data_q, skid_data_q;

	// next-state logic
	logic                      in_accept, out_take;
	logic [pdt_pkg::CNT_W-1:0] new_period, count_dec;
	logic [pdt_pkg::CNT_W-1:0] tick_count_d, period_d;
	logic                      square_mode_d, paused_d, output_level_d, irq_d;
	pdt_pkg::out_t             result;

	assign in_ready  = !skid_valid_q;
	assign in_accept = in_valid && in_ready;
	assign out_take  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign new_period = pdt_pkg::period_of(in_data.control_byte);
	assign count_dec  = tick_count_q - pdt_pkg::CNT_W'(1);

	// write or tick update of the timer
	always_comb begin
		tick_count_d   = tick_count_q;
		period_d       = period_q;
		square_mode_d  = square_mode_q;
		paused_d       = paused_q;
		output_level_d = output_level_q;
		irq_d          = 1'b0;
		case (in_data.command)
			pdt_pkg::CMD_WRITE: begin
				output_level_d = 1'b1;
				period_d       = new_period;
				square_mode_d  = !in_data.control_byte[pdt_pkg::CB_RANGE]
					&& !in_data.control_byte[pdt_pkg::CB_SET];
				tick_count_d   = in_data.control_byte[pdt_pkg::CB_RESET] ?
					new_period : (new_period >> 1);
				paused_d       = in_data.control_byte[pdt_pkg::CB_PAUSE];
			end
			pdt_pkg::CMD_TICK: begin
				if (tick_count_q != '0 && !paused_q) begin
					tick_count_d = count_dec;
					if (count_dec == '0) begin
						irq_d = 1'b1;
						if (square_mode_q) begin
							output_level_d = !output_level_q;
							tick_count_d   = period_q >> 1;
						end else begin
							output_level_d = 1'b0;
							tick_count_d   = period_q;
						end
					end
				end
			end
			default: begin
				irq_d = 1'b0;
			end
		endcase
		result.timer_level = output_level_d;
		result.interrupt   = irq_d;
	end

	// timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= '0;
			period_q       <= '0;
			square_mode_q  <= 1'b0;
			paused_q       <= 1'b1;
			output_level_q <= 1'b1;
		end else if (in_accept) begin
			tick_count_q   <= tick_count_d;
			period_q       <= period_d;
			square_mode_q  <= square_mode_d;
			paused_q       <= paused_d;
			output_level_q <= output_level_d;
		end
	end

	// result slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!in_accept) begin
					out_valid_q <= 1'b0;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= in_accept;
			end else if (in_accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_accept) begin
				out_data_q <= result;
			end
		end else if (!out_valid_q) begin
			if (in_accept) begin
				out_data_q <= result;
			end
		end else if (in_accept) begin
			skid_data_q <= result;
		end
	end

	// the skid stage only fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a beat with the output register empty");

	// the counter never runs above the loaded period
	a_count_le_period: assert property (@(posedge clk) disable iff (!arst_n)
		tick_count_q <= period_q)
		else $error("tick count above period");

	// a control-byte write always leaves the output high
	a_write_sets_level: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_data.command == pdt_pkg::CMD_WRITE) |=> output_level_q)
		else $error("output level low after a control-byte write");

	// a tick while paused leaves the counter alone
	a_pause_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_data.command == pdt_pkg::CMD_TICK && paused_q)
		|=> $stable(tick_count_q))
		else $error("counter moved while paused");

endmodule

`default_nettype wire

### tb/sv/timer_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_tb_pkg
// Scoreboard for the programmable divider timer: a cycle-free model of the
// timer state predicts the level and interrupt of every accepted beat, and
// result beats are checked in order against those predictions.
// ----------------------------------------------------------------------------

package timer_tb_pkg;

	class timer_scoreboard;
		logic [pdt_pkg::CNT_W-1:0] count_left;
		logic [pdt_pkg::CNT_W-1:0] period_len;
		logic                      square;
		logic                      halted;
		logic                      level;
		pdt_pkg::out_t             level_irq_q[$];
		int unsigned               failures;
		int unsigned               results_seen;

		function new();
			count_left   = '0;
			period_len   = '0;
			square       = 1'b0;
			halted       = 1'b1;
			level        = 1'b1;
			failures     = 0;
			results_seen = 0;
		endfunction

		// advance the timer by one beat and give the level and interrupt
		function pdt_pkg::out_t timer_step(input pdt_pkg::in_t beat);
			pdt_pkg::out_t             r;
			logic [pdt_pkg::CNT_W-1:0] base;
			r.interrupt = 1'b0;
			if (beat.command == pdt_pkg::CMD_WRITE) begin
				// control byte: new period, mode and counter load, level forced high
				base       = beat.control_byte[pdt_pkg::CB_RANGE] ?
					pdt_pkg::SHORT_BASE : pdt_pkg::LONG_BASE;
				period_len = base << beat.control_byte[3:0];
				square     = !beat.control_byte[pdt_pkg::CB_RANGE]
					&& !beat.control_byte[pdt_pkg::CB_SET];
				count_left = beat.control_byte[pdt_pkg::CB_RESET] ?
					period_len : (period_len >> 1);
				halted     = beat.control_byte[pdt_pkg::CB_PAUSE];
				level      = 1'b1;
			end else if (count_left != '0 && !halted) begin
				// live tick: count down, expire and reload
				count_left = count_left - 1'b1;
				if (count_left == '0) begin
					r.interrupt = 1'b1;
					if (square) begin
						level      = !level;
						count_left = period_len >> 1;
					end else begin
						level      = 1'b0;
						count_left = period_len;
					end
				end
			end
			r.timer_level = level;
			return r;
		endfunction

		// accepted input beat
		function void note_beat(input pdt_pkg::in_t beat);
			level_irq_q.push_back(timer_step(beat));
		endfunction

		function int pending();
			return level_irq_q.size();
		endfunction

		task report_mismatch(input string what);
			$display("mismatch: %s", what);
			failures++;
		endtask

		// accepted result beat against the oldest prediction
		task check_beat(input pdt_pkg::out_t got);
			pdt_pkg::out_t want;
			if (level_irq_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result level=%0b irq=%0b",
					got.timer_level, got.interrupt));
				return;
			end
			want = level_irq_q.pop_front();
			if (got.timer_level !== want.timer_level)
				report_mismatch($sformatf("result %0d timer_level got %0b want %0b",
					results_seen, got.timer_level, want.timer_level));
			if (got.interrupt !== want.interrupt)
				report_mismatch($sformatf("result %0d interrupt got %0b want %0b",
					results_seen, got.interrupt, want.interrupt));
			results_seen++;
		endtask
	endclass

endpackage

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for programmable_divider_timer_unit: a directed pass over the
// control-byte extremes, then random write and tick sequences, with bursty
// input and a stalling receiver; every result beat is checked in order.
// ----------------------------------------------------------------------------

module tb;

	localparam int unsigned ITEMS        = 1850;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum int unsigned {RX_FLOW, RX_CHOPPY, RX_CLOGGED} rx_mode_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	pdt_pkg::in_t   in_data;
	logic           out_valid;
	logic           out_ready;
	pdt_pkg::out_t  out_data;

	timer_tb_pkg::timer_scoreboard sb;
	int unsigned     beats_sent  = 0;
	int unsigned     burst_left  = 0;
	int unsigned     idle_cycles = 0;
	rx_mode_t        rx_mode     = RX_FLOW;
	int unsigned     rx_left     = 0;

	programmable_divider_timer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: free-flowing, choppy or clogged stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FLOW:   out_ready <= 1'b1;
			RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
			default:   out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// beat monitor and idle counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_beat(in_data);
			if (out_valid && out_ready)
				sb.check_beat(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// one input beat, with bursts and gaps
	task automatic send_beat(input logic cmd, input logic [7:0] cb);
		int unsigned   gap;
		pdt_pkg::in_t  beat;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(100, 300);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 30);
				gap        = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		beat.command      = cmd;
		beat.control_byte = cb;
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	task automatic write_control(input logic [7:0] cb);
		send_beat(pdt_pkg::CMD_WRITE, cb);
	endtask

	// ticks carry a random control byte, which the block must ignore
	task automatic tick_run(input int unsigned n);
		repeat (n) send_beat(pdt_pkg::CMD_TICK, 8'($urandom));
	endtask

	initial begin
		int unsigned pick;
		logic [7:0]  cb;
		sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks straight after reset do nothing
		tick_run(3);
		// extremes of the control byte and each mode
		write_control(8'h00);
		tick_run(2);
		write_control(8'hFF);
		tick_run(2);
		write_control(8'h7F);
		tick_run(1);
		write_control(8'h4F);
		tick_run(1);
		write_control(8'h0F);
		tick_run(1);
		// shortest period: expiry on the first tick
		write_control(8'h10);
		tick_run(3);
		write_control(8'h50);
		tick_run(2);
		write_control(8'h20);
		tick_run(1);
		// paused timer ignores ticks
		write_control(8'h90);
		tick_run(1);

		// random sequences: a write then a run of ticks
		while (beats_sent < ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// short range, small divider: frequent expiry
				cb = {($urandom_range(0, 7) == 0), 2'($urandom_range(0, 3)), 1'b1,
					4'($urandom_range(0, 3))};
				write_control(cb);
				tick_run($urandom_range(1, 40));
			end else if (pick < 68) begin
				// long range, smallest divider: square wave or one-shot
				cb = {($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b0, 4'h0};
				write_control(cb);
				tick_run($urandom_range(250, 560));
			end else if (pick < 92) begin
				// any control byte, cut short
				write_control(8'($urandom));
				tick_run($urandom_range(0, 8));
			end else begin
				tick_run($urandom_range(1, 6));
			end
		end
		in_valid <= 1'b0;

		// drain, once the monitor has seen the last input beat
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
src/pdt_pkg.sv
src/programmable_divider_timer_unit.sv
tb/sv/timer_tb_pkg.sv
tb/sv/tb.sv
